// ===== design/hic_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Homography inlier classifier package
// Shared constants and the register index type of the classifier.
// ----------------------------------------------------------------------------
package hic_pkg;

  // Width of a signed projected coordinate in Q.4, saturated to -2^30 .. 2^30-1.
  localparam int QUO_BITS = 31;
  // Width of one packed coefficient row register.
  localparam int ROW_W = 63;
  // Width of the threshold and of the squared error.
  localparam int ERR_W = 32;
  // Configuration port.
  localparam int APB_DW = 64;
  localparam int APB_AW = 6;

  typedef enum logic [2:0] {
    REG_H_ROW0    = 3'd0,
    REG_H_ROW1    = 3'd1,
    REG_H_ROW2    = 3'd2,
    REG_INV_ROW0  = 3'd3,
    REG_INV_ROW1  = 3'd4,
    REG_INV_ROW2  = 3'd5,
    REG_THRESHOLD = 3'd6
  } reg_idx_t;

endpackage

// ===== design/hic_divider.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pipelined projection divider
// Signed (num * 16) / den, truncated toward zero, saturated to 31 bits.
// One quotient bit is resolved in each g_step register stage.
// ----------------------------------------------------------------------------
module hic_divider
  import hic_pkg::*;
#(
  parameter int NW = 36
) (
  input  logic                       clk,
  input  logic                       en,
  input  logic signed [NW-1:0]       num,
  input  logic signed [NW-1:0]       den,
  output logic signed [QUO_BITS-1:0] quo
);

  localparam int NMW = NW + 4;
  localparam int CW  = NW + QUO_BITS + 5;

  logic [NMW-1:0]      rem  [0:QUO_BITS];
  logic [NW-1:0]       dmag [0:QUO_BITS];
  logic [QUO_BITS-1:0] qacc [0:QUO_BITS];
  logic                neg  [0:QUO_BITS];
  logic                ovf  [0:QUO_BITS];

  logic [NW-1:0]  num_abs;
  logic [NW-1:0]  den_abs;
  logic [NMW-1:0] num_sh;

  assign num_abs = num[NW-1] ? NW'(-num) : NW'(num);
  assign den_abs = den[NW-1] ? NW'(-den) : NW'(den);
  assign num_sh  = {num_abs, 4'b0000};

  // The quotient overflows 31 bits when |num*16| >= |den| * 2^31.
  always_ff @(posedge clk) begin
    if (en) begin
      rem[0]  <= num_sh;
      dmag[0] <= den_abs;
      qacc[0] <= '0;
      neg[0]  <= num[NW-1] ^ den[NW-1];
      ovf[0]  <= CW'(num_sh) >= (CW'(den_abs) << QUO_BITS);
    end
  end

  for (genvar s = 0; s < QUO_BITS; s++) begin : g_step
    localparam int BIT = QUO_BITS - 1 - s;
    logic [CW:0] trial;
    assign trial = (CW + 1)'(rem[s]) - ((CW + 1)'(dmag[s]) << BIT);
    always_ff @(posedge clk) begin
      if (en) begin
        rem[s+1]  <= trial[CW] ? rem[s] : trial[NMW-1:0];
        qacc[s+1] <= qacc[s] | (trial[CW] ? '0 : (QUO_BITS'(1) << BIT));
        dmag[s+1] <= dmag[s];
        neg[s+1]  <= neg[s];
        ovf[s+1]  <= ovf[s];
      end
    end
  end

  logic [QUO_BITS-1:0] mag;
  assign mag = qacc[QUO_BITS];

  always_ff @(posedge clk) begin
    if (en) begin
      if (ovf[QUO_BITS] || mag[QUO_BITS-1]) begin
        quo <= neg[QUO_BITS] ? {1'b1, {(QUO_BITS-1){1'b0}}} : {1'b0, {(QUO_BITS-1){1'b1}}};
      end else begin
        quo <= neg[QUO_BITS] ? QUO_BITS'(-mag) : mag;
      end
    end
  end

endmodule

// ===== design/homography_inlier_classifier.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Homography inlier classifier
// Symmetric transfer error test of one point correspondence per cycle, unless stalled.
// ----------------------------------------------------------------------------
//  Channel   Signals                              Direction
//  input     in_valid, in_stall, dom_*, rng_*     correspondence in
//  output    out_valid, out_stall, results        classification out
//  config    psel, penable, pwrite, paddr, ...    APB register access
//
// One transfer is taken in every cycle while in_stall is low; the divider
// resolves one quotient bit per stage. Reset clears the valid bits and loads
// the identity matrices and a threshold of 4.0 square pixels. A stall on the
// output holds the whole pipeline, and the input is stalled while a held
// result is waiting.
// ----------------------------------------------------------------------------
module homography_inlier_classifier
  import hic_pkg::*;
#(
  parameter int COORD_BITS     = 12,
  parameter int COEF_BITS      = 21,
  parameter int COEF_FRAC_BITS = 10
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_AW-1:0]     paddr,
  input  logic [APB_DW-1:0]     pwdata,
  output logic [APB_DW-1:0]     prdata,
  output logic                  pready,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [COORD_BITS-1:0] dom_x,
  input  logic [COORD_BITS-1:0] dom_y,
  input  logic [COORD_BITS-1:0] rng_x,
  input  logic [COORD_BITS-1:0] rng_y,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  is_inlier,
  output logic [ERR_W-1:0]      sq_error,
  output logic                  degenerate,
  output logic [COORD_BITS-1:0] out_dom_x,
  output logic [COORD_BITS-1:0] out_dom_y,
  output logic [COORD_BITS-1:0] out_rng_x,
  output logic [COORD_BITS-1:0] out_rng_y
);

  // Product of a signed coefficient and a coordinate made signed.
  localparam int PW      = COEF_BITS + COORD_BITS + 1;
  // Sum of two products and a constant coefficient.
  localparam int NW      = PW + 2;
  localparam int DIV_LAT = QUO_BITS + 2;
  localparam int DW      = QUO_BITS + 2;

  localparam logic [ROW_W-1:0] ONE_C = ROW_W'(1) << COEF_FRAC_BITS;

  typedef struct packed {
    logic                  degen;
    logic [COORD_BITS-1:0] dx;
    logic [COORD_BITS-1:0] dy;
    logic [COORD_BITS-1:0] rx;
    logic [COORD_BITS-1:0] ry;
  } pass_t;

  // --------------------------------------------------------------------------
  // Configuration registers. Writes must arrive only while the pipeline is empty; the block does not enforce it.
  // --------------------------------------------------------------------------
  logic [ROW_W-1:0] rows [0:5];
  logic [ERR_W-1:0] threshold;
  reg_idx_t         widx;

  assign widx   = reg_idx_t'(paddr[APB_AW-1:3]);
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      rows[0]   <= ONE_C;
      rows[1]   <= ONE_C << COEF_BITS;
      rows[2]   <= ONE_C << (2 * COEF_BITS);
      rows[3]   <= ONE_C;
      rows[4]   <= ONE_C << COEF_BITS;
      rows[5]   <= ONE_C << (2 * COEF_BITS);
      threshold <= ERR_W'(64);
    end else if (psel && penable && pwrite) begin
      unique case (widx)
        REG_H_ROW0, REG_H_ROW1, REG_H_ROW2,
        REG_INV_ROW0, REG_INV_ROW1, REG_INV_ROW2: rows[widx] <= pwdata[ROW_W-1:0];
        REG_THRESHOLD: threshold <= pwdata[ERR_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (widx)
      REG_H_ROW0, REG_H_ROW1, REG_H_ROW2,
      REG_INV_ROW0, REG_INV_ROW1, REG_INV_ROW2: prdata = APB_DW'(rows[widx]);
      REG_THRESHOLD: prdata = APB_DW'(threshold);
      default:       prdata = '0;
    endcase
  end

  function automatic logic signed [COEF_BITS-1:0] coef(input logic [ROW_W-1:0] row,
                                                        input int k);
    return row[k*COEF_BITS +: COEF_BITS];
  endfunction

  // --------------------------------------------------------------------------
  // The whole pipeline advances together unless a held result is waiting.
  // --------------------------------------------------------------------------
  logic en;
  assign en       = !out_valid || !out_stall;
  assign in_stall = !en;

  // Stage 1: coefficient products. Projection 0 is the forward map of the
  // domain point, projection 1 the inverse map of the range point.
  logic                        v1;
  pass_t                       p1;
  logic signed [PW-1:0]        prod [0:1][0:2][0:1];
  logic signed [COEF_BITS-1:0] cst  [0:1][0:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1 <= '{degen: 1'b0, dx: dom_x, dy: dom_y, rx: rng_x, ry: rng_y};
      for (int r = 0; r < 3; r++) begin
        prod[0][r][0] <= coef(rows[r], 0) * $signed({1'b0, dom_x});
        prod[0][r][1] <= coef(rows[r], 1) * $signed({1'b0, dom_y});
        prod[1][r][0] <= coef(rows[r+3], 0) * $signed({1'b0, rng_x});
        prod[1][r][1] <= coef(rows[r+3], 1) * $signed({1'b0, rng_y});
        cst[0][r]     <= coef(rows[r], 2);
        cst[1][r]     <= coef(rows[r+3], 2);
      end
    end
  end

  // Stage 2: numerators and w terms.
  logic                 v2;
  pass_t                p2;
  logic signed [NW-1:0] dot [0:1][0:2];
  logic signed [NW-1:0] dot_next [0:1][0:2];

  always_comb begin
    for (int p = 0; p < 2; p++) begin
      for (int r = 0; r < 3; r++) begin
        dot_next[p][r] = NW'(prod[p][r][0]) + NW'(prod[p][r][1]) + NW'(cst[p][r]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dot <= dot_next;
      p2  <= '{degen: (dot_next[0][2] == '0) || (dot_next[1][2] == '0),
               dx: p1.dx, dy: p1.dy, rx: p1.rx, ry: p1.ry};
    end
  end

  // Dividers: forward x, forward y, inverse x, inverse y.
  logic signed [QUO_BITS-1:0] proj [0:3];

  for (genvar u = 0; u < 4; u++) begin : g_div
    hic_divider #(.NW(NW)) u_div (
      .clk (clk),
      .en  (en),
      .num (dot[u/2][u%2]),
      .den (dot[u/2][2]),
      .quo (proj[u])
    );
  end

  // Side information travels beside the dividers.
  logic [DIV_LAT-1:0] vline;
  pass_t              pline [0:DIV_LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vline <= '0;
    end else if (en) begin
      vline <= {vline[DIV_LAT-2:0], v2};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pline[0] <= p2;
      for (int i = 1; i < DIV_LAT; i++) begin
        pline[i] <= pline[i-1];
      end
    end
  end

  // Stage D: magnitudes of the transfer differences in Q.4.
  pass_t                pe;
  logic                 vd;
  pass_t                pd;
  logic [DW-2:0]        dmag [0:3];
  logic signed [DW-1:0] diff [0:3];
  logic [COORD_BITS-1:0] partner [0:3];

  assign pe         = pline[DIV_LAT-1];
  assign partner[0] = pe.rx;
  assign partner[1] = pe.ry;
  assign partner[2] = pe.dx;
  assign partner[3] = pe.dy;

  always_comb begin
    for (int u = 0; u < 4; u++) begin
      diff[u] = DW'($signed({1'b0, partner[u], 4'b0000})) - DW'(proj[u]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vd <= 1'b0;
    end else if (en) begin
      vd <= vline[DIV_LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pd <= pe;
      for (int u = 0; u < 4; u++) begin
        dmag[u] <= diff[u][DW-1] ? (DW-1)'(-diff[u]) : diff[u][DW-2:0];
      end
    end
  end

  // Stage Q: squares with eight fraction bits.
  logic              vq;
  pass_t             pq;
  logic [2*DW-3:0]   sq [0:3];

  always_ff @(posedge clk) begin
    if (rst) begin
      vq <= 1'b0;
    end else if (en) begin
      vq <= vd;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pq <= pd;
      for (int u = 0; u < 4; u++) begin
        sq[u] <= dmag[u] * dmag[u];
      end
    end
  end

  // Output stage: sum, drop four fraction bits, saturate and compare.
  logic [2*DW-1:0] sum;
  logic [2*DW-5:0] err_full;
  logic [ERR_W-1:0] err;

  assign sum      = (2*DW)'(sq[0]) + (2*DW)'(sq[1]) + (2*DW)'(sq[2]) + (2*DW)'(sq[3]);
  assign err_full = sum[2*DW-1:4];
  assign err      = (pq.degen || (|err_full[2*DW-5:ERR_W])) ? '1 : err_full[ERR_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= vq;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq_error   <= err;
      degenerate <= pq.degen;
      is_inlier  <= !pq.degen && (err < threshold);
      out_dom_x  <= pq.dx;
      out_dom_y  <= pq.dy;
      out_rng_x  <= pq.rx;
      out_rng_y  <= pq.ry;
    end
  end

endmodule

// ===== design/hic_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Homography inlier classifier checker
// Port-level properties of the classifier, bound to the top level.
// ----------------------------------------------------------------------------
module hic_checker
  import hic_pkg::*;
(
  input logic             clk,
  input logic             rst,
  input logic             out_valid,
  input logic             out_stall,
  input logic             is_inlier,
  input logic             degenerate,
  input logic [ERR_W-1:0] sq_error
);

  a_reset_empty : assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  a_degen_not_inlier : assert property (@(posedge clk) disable iff (rst)
    out_valid && degenerate |-> !is_inlier)
    else $error("degenerate item flagged inlier");

  a_degen_saturated : assert property (@(posedge clk) disable iff (rst)
    out_valid && degenerate |-> sq_error == '1)
    else $error("degenerate item without saturated error");

  a_hold : assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(sq_error) && $stable(is_inlier))
    else $error("stalled result changed");

endmodule

bind homography_inlier_classifier hic_checker u_hic_checker (
  .clk        (clk),
  .rst        (rst),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .is_inlier  (is_inlier),
  .degenerate (degenerate),
  .sq_error   (sq_error)
);

// ===== dv/tb_homography_inlier_classifier.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Homography inlier classifier testbench
// Streams point correspondences through the classifier under random input gaps
// and output stalls. A behavioural scorer in this file predicts every
// classification, and each result transfer is checked against it. The
// homography, its inverse and the threshold are reprogrammed between phases,
// and only once the pipeline has drained.
// ----------------------------------------------------------------------------
module tb_homography_inlier_classifier;
  import hic_pkg::*;

  localparam int CB       = 12;
  localparam int KB       = 21;
  // Pipeline depth of the classifier, used for the final drain.
  localparam int LATENCY  = QUO_BITS + 7;
  // Cycles without any transfer before the run is declared hung.
  localparam int IDLE_LIM = 5000;
  localparam longint PROJ_HI = 64'sd1073741823;
  localparam longint PROJ_LO = -64'sd1073741824;

  typedef struct packed {
    logic          is_inlier;
    logic [31:0]   sq_error;
    logic          degenerate;
    logic [CB-1:0] dx, dy, rx, ry;
  } verdict_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [APB_AW-1:0] paddr = '0;
  logic [APB_DW-1:0] pwdata = '0;
  logic [APB_DW-1:0] prdata;
  logic pready;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [CB-1:0] dom_x = '0, dom_y = '0, rng_x = '0, rng_y = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic is_inlier, degenerate;
  logic [ERR_W-1:0] sq_error;
  logic [CB-1:0] out_dom_x, out_dom_y, out_rng_x, out_rng_y;

  // Shadow copy of the register file as the scorer sees it.
  logic [ROW_W-1:0] row_shadow [6];
  logic [ERR_W-1:0] thr_shadow;

  verdict_t pending_q[$];
  int  fail_count = 0;
  int  idle_cycles = 0;
  // When set, neither side idles: back-to-back transfers.
  bit  calm = 1'b0;
  int  stall_left = 0;

  homography_inlier_classifier dut (.*);

  always #4 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Scorer: fixed-point projection in both directions, as the block defines it.
  // ---------------------------------------------------------------------------
  function automatic longint coef_of(logic [ROW_W-1:0] row, int k);
    logic signed [KB-1:0] c;
    c = row[k*KB +: KB];
    return longint'(c);
  endfunction

  function automatic longint row_dot(logic [ROW_W-1:0] row, longint x, longint y);
    return coef_of(row, 0) * x + coef_of(row, 1) * y + coef_of(row, 2);
  endfunction

  function automatic longint clamp_quot(longint num, longint w);
    longint q;
    q = (num * 16) / w;
    if (q > PROJ_HI) q = PROJ_HI;
    if (q < PROJ_LO) q = PROJ_LO;
    return q;
  endfunction

  function automatic logic [63:0] sq_gap(longint coord, longint proj);
    longint d;
    logic [63:0] m;
    d = coord * 16 - proj;
    m = (d < 0) ? -d : d;
    return m * m;
  endfunction

  function automatic verdict_t classify(logic [CB-1:0] dx, dy, rx, ry);
    verdict_t v;
    longint wf, wb, fx, fy, bx, by;
    longint lx, ly, mx, my;
    logic [63:0] sum;
    lx = longint'(dx); ly = longint'(dy);
    mx = longint'(rx); my = longint'(ry);
    wf = row_dot(row_shadow[2], lx, ly);
    wb = row_dot(row_shadow[5], mx, my);
    v.dx = dx; v.dy = dy; v.rx = rx; v.ry = ry;
    v.degenerate = (wf == 0) || (wb == 0);
    if (v.degenerate) begin
      v.sq_error  = '1;
      v.is_inlier = 1'b0;
    end else begin
      fx = clamp_quot(row_dot(row_shadow[0], lx, ly), wf);
      fy = clamp_quot(row_dot(row_shadow[1], lx, ly), wf);
      bx = clamp_quot(row_dot(row_shadow[3], mx, my), wb);
      by = clamp_quot(row_dot(row_shadow[4], mx, my), wb);
      sum = sq_gap(mx, fx) + sq_gap(my, fy) + sq_gap(lx, bx) + sq_gap(ly, by);
      sum = sum >> 4;
      v.sq_error  = (sum > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : sum[31:0];
      v.is_inlier = v.sq_error < thr_shadow;
    end
    return v;
  endfunction

  function automatic logic [ROW_W-1:0] pack_row(int c0, int c1, int c2);
    logic [KB-1:0] a, b, c;
    a = KB'(c0); b = KB'(c1); c = KB'(c2);
    return {c, b, a};
  endfunction

  // Mostly short gaps, occasionally a long one; none while calm.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (calm) return 0;
    if (r < 65) return 0;
    if (r < 95) return $urandom_range(3, 1);
    return $urandom_range(60, 10);
  endfunction

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------
  // APB write: setup cycle, then access cycle; the register takes the value at
  // the edge closing the access cycle since pready is always high.
  task automatic reg_write(reg_idx_t idx, logic [APB_DW-1:0] value);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= APB_AW'(8 * int'(idx)); pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (idx == REG_THRESHOLD) thr_shadow = value[ERR_W-1:0];
    else row_shadow[int'(idx)] = value[ROW_W-1:0];
  endtask

  // Write to the unused eighth slot: the block must ignore it.
  task automatic reg_write_unmapped(logic [APB_DW-1:0] value);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= APB_AW'(56); pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  task automatic load_matrices(logic [ROW_W-1:0] h0, h1, h2, i0, i1, i2,
                               logic [31:0] thr);
    reg_write(REG_H_ROW0, {1'b0, h0});
    reg_write(REG_H_ROW1, {1'b0, h1});
    reg_write(REG_H_ROW2, {1'b0, h2});
    reg_write(REG_INV_ROW0, {1'b0, i0});
    reg_write(REG_INV_ROW1, {1'b0, i1});
    reg_write(REG_INV_ROW2, {1'b0, i2});
    reg_write(REG_THRESHOLD, {32'h0, thr});
  endtask

  // One correspondence transfer; the prediction is queued when it is taken.
  task automatic send_pair(logic [CB-1:0] dx, dy, rx, ry);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    dom_x <= dx; dom_y <= dy; rng_x <= rx; rng_y <= ry;
    do @(posedge clk); while (in_stall);
    pending_q.push_back(classify(dx, dy, rx, ry));
  endtask

  // Hold the sender off until every prediction has been matched.
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  // Output stall: bursts of random length, most short, some long.
  always @(posedge clk) begin
    if (calm) begin
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
    end else begin
      case ($urandom_range(19))
        0:       begin out_stall <= 1'b1; stall_left <= $urandom_range(70, 15); end
        1, 2, 3: begin out_stall <= 1'b1; stall_left <= $urandom_range(3); end
        default: begin out_stall <= 1'b0; stall_left <= $urandom_range(6); end
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Result checker and watchdog
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    verdict_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_q.size() == 0) begin
        $display("%0t: result transfer with nothing predicted: err=%h deg=%b",
                 $time, sq_error, degenerate);
        fail_count++;
      end else begin
        want = pending_q.pop_front();
        if (is_inlier !== want.is_inlier) begin
          $display("%0t: is_inlier expected %b actual %b", $time, want.is_inlier, is_inlier);
          fail_count++;
        end
        if (sq_error !== want.sq_error) begin
          $display("%0t: sq_error expected %h actual %h", $time, want.sq_error, sq_error);
          fail_count++;
        end
        if (degenerate !== want.degenerate) begin
          $display("%0t: degenerate expected %b actual %b", $time, want.degenerate,
                   degenerate);
          fail_count++;
        end
        if ({out_dom_x, out_dom_y, out_rng_x, out_rng_y} !==
            {want.dx, want.dy, want.rx, want.ry}) begin
          $display("%0t: coords expected %h %h %h %h actual %h %h %h %h", $time,
                   want.dx, want.dy, want.rx, want.ry,
                   out_dom_x, out_dom_y, out_rng_x, out_rng_y);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIM) begin
        $display("%0t: no transfer for %0d cycles", $time, IDLE_LIM);
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // Reset matrices are the identity with a threshold of 4.0: exact matches,
  // small offsets either side of the threshold, and the coordinate extremes.
  task automatic test_identity_defaults();
    calm = 1'b1;
    send_pair(12'd0, 12'd0, 12'd0, 12'd0);
    send_pair(12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF);
    send_pair(12'd100, 12'd200, 12'd101, 12'd200);   // error 2.0, inlier
    send_pair(12'd100, 12'd200, 12'd101, 12'd201);   // error exactly at limit
    send_pair(12'd100, 12'd200, 12'd102, 12'd200);
    send_pair(12'd0, 12'hFFF, 12'hFFF, 12'd0);
    send_pair(12'hFFF, 12'd0, 12'd0, 12'hFFF);
    calm = 1'b0;
    send_pair(12'hAAA, 12'h555, 12'hAAA, 12'h554);
    send_pair(12'h555, 12'hAAA, 12'h556, 12'hAAA);
    drain();
  endtask

  // A w row of zero, a w row that vanishes at one of the points sent, and such a
  // row on the inverse side. The unmapped slot is written too and must change nothing.
  task automatic test_zero_w();
    reg_write(REG_H_ROW2, 64'h0);
    reg_write_unmapped(64'hFFFF_FFFF_FFFF_FFFF);
    send_pair(12'd5, 12'd6, 12'd5, 12'd6);
    send_pair(12'hFFF, 12'hFFF, 12'd0, 12'd0);
    drain();
    reg_write(REG_H_ROW2, {1'b0, pack_row(-1024, 0, 5 * 1024)});
    send_pair(12'd5, 12'd9, 12'd5, 12'd9);          // w vanishes here
    send_pair(12'd4, 12'd9, 12'd4, 12'd9);
    send_pair(12'd6, 12'd9, 12'd6, 12'd9);
    drain();
    reg_write(REG_H_ROW2, {1'b0, pack_row(0, 0, 1024)});
    reg_write(REG_INV_ROW2, {1'b0, pack_row(0, -1024, 7 * 1024)});
    send_pair(12'd3, 12'd7, 12'd3, 12'd7);          // inverse w vanishes
    send_pair(12'd3, 12'd7, 12'd3, 12'd8);
    drain();
  endtask

  // Tiny w drives the quotient to its clamp; coefficient extremes and the
  // threshold at both ends.
  task automatic test_saturation();
    load_matrices(pack_row(1024, 0, 0), pack_row(0, 1024, 0), pack_row(0, 0, 1),
                  pack_row(1024, 0, 0), pack_row(0, 1024, 0), pack_row(0, 0, -1),
                  32'hFFFF_FFFF);
    send_pair(12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF);
    send_pair(12'd1, 12'd0, 12'd0, 12'd1);
    send_pair(12'd0, 12'd0, 12'd0, 12'd0);
    drain();
    load_matrices(pack_row(-1048576, 1048575, -1048576),
                  pack_row(1048575, -1048576, 1048575),
                  pack_row(0, 0, -1048576),
                  pack_row(1048575, 1048575, 1048575),
                  pack_row(-1048576, -1048576, -1048576),
                  pack_row(1, 1, 1), 32'h0);
    send_pair(12'hFFF, 12'd0, 12'd0, 12'hFFF);
    send_pair(12'd0, 12'd0, 12'd0, 12'd0);
    send_pair(12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF);
    drain();
    // Bit 63 of the write data lies outside the rows and must be dropped.
    reg_write(REG_H_ROW0, {1'b1, pack_row(1024, 0, 0)});
    reg_write(REG_H_ROW1, {1'b1, pack_row(0, 1024, 0)});
    reg_write(REG_H_ROW2, {1'b1, pack_row(0, 0, 1024)});
    reg_write(REG_INV_ROW0, {1'b1, pack_row(1024, 0, 0)});
    reg_write(REG_INV_ROW1, {1'b1, pack_row(0, 1024, 0)});
    reg_write(REG_INV_ROW2, {1'b1, pack_row(0, 0, 1024)});
    reg_write(REG_THRESHOLD, 64'hFFFF_FFFF_0000_0040);
    send_pair(12'd10, 12'd10, 12'd11, 12'd11);
    send_pair(12'd10, 12'd10, 12'd10, 12'd11);
    drain();
  endtask

  // Random phases: near-identity matrices with matching points offset by a
  // little noise, fully random matrices, and random correspondences.
  task automatic test_random_phases();
    int phase, n, j;
    logic [CB-1:0] dx, dy, rx, ry;
    logic [31:0] thr;
    for (phase = 0; phase < 12; phase++) begin
      case ($urandom_range(3))
        0: thr = 32'h0;
        1: thr = 32'hFFFF_FFFF;
        2: thr = $urandom;
        default: thr = $urandom_range(4096);
      endcase
      if (phase % 3 == 2) begin
        load_matrices(ROW_W'({$urandom, $urandom}), ROW_W'({$urandom, $urandom}),
                      ROW_W'({$urandom, $urandom}), ROW_W'({$urandom, $urandom}),
                      ROW_W'({$urandom, $urandom}), ROW_W'({$urandom, $urandom}),
                      thr);
      end else begin
        j = $urandom_range(8) - 4;
        load_matrices(pack_row(1024 + j, $urandom_range(8) - 4, $urandom_range(64) - 32),
                      pack_row($urandom_range(8) - 4, 1024 - j, $urandom_range(64) - 32),
                      pack_row(0, 0, 1024),
                      pack_row(1024 - j, 0, $urandom_range(64) - 32),
                      pack_row(0, 1024 + j, $urandom_range(64) - 32),
                      pack_row($urandom_range(2) - 1, $urandom_range(2) - 1,
                               1024 + $urandom_range(4) - 2),
                      thr);
      end
      calm = (phase == 4);
      for (n = 0; n < 125; n++) begin
        dx = CB'($urandom); dy = CB'($urandom);
        if ($urandom_range(9) < 7) begin
          rx = dx + CB'($urandom_range(6) - 3);
          ry = dy + CB'($urandom_range(6) - 3);
        end else begin
          rx = CB'($urandom); ry = CB'($urandom);
        end
        send_pair(dx, dy, rx, ry);
        if ($urandom_range(199) == 0) drain();
      end
      drain();
    end
    calm = 1'b0;
  endtask

  initial begin
    row_shadow[0] = pack_row(1024, 0, 0);
    row_shadow[1] = pack_row(0, 1024, 0);
    row_shadow[2] = pack_row(0, 0, 1024);
    row_shadow[3] = row_shadow[0];
    row_shadow[4] = row_shadow[1];
    row_shadow[5] = row_shadow[2];
    thr_shadow = 32'd64;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_identity_defaults();
    test_zero_w();
    test_saturation();
    test_random_phases();

    in_valid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (3 * LATENCY) @(posedge clk);
    if (pending_q.size() != 0) fail_count++;
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
